[hw/rtl/mep_pkg.sv]
// Shared constants and types of the Mandelbrot escape-time pixel block.
package mep_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 28;

  localparam int PIX_BITS   = $clog2(MAX_DIMENSION);
  localparam int DIM_BITS   = PIX_BITS + 1;
  localparam int COORD_BITS = FRACTION_BITS + 4;
  localparam int MAG_BITS   = FRACTION_BITS + 1;
  localparam int PROD_BITS  = 2 * MAG_BITS;
  localparam int DVD_BITS   = PIX_BITS + 1 + FRACTION_BITS;
  localparam int DCNT_BITS  = $clog2(DVD_BITS);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 16;

  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(512);
  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(512);
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET  = COUNT_BITS'(256);

  localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIMENSION);
  localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

  localparam logic [COORD_BITS-1:0] RE_OFFSET = COORD_BITS'(3) << (FRACTION_BITS - 1);
  localparam logic [COORD_BITS-1:0] IM_OFFSET = COORD_BITS'(1) << FRACTION_BITS;

  localparam logic [COORD_BITS-1:0] Q_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] Q_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [DCNT_BITS-1:0] DIV_LAST = DCNT_BITS'(DVD_BITS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_HEIGHT   = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_MAX_ITER = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP,
    ST_SQR,
    ST_SQI,
    ST_MXY,
    ST_UPD,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/mandelbrot_escape_pixel.sv]
// Mandelbrot escape-time pixel: maps a pixel to a point and counts iterations.
// The two coordinates come from a one-bit-per-cycle divider.
// Each iteration runs through the states SQR, SQI, MXY and UPD on one shared 29 x 29 multiplier.
// One pixel at a time; the next input word can be taken in the cycle after the result loads.
// rst_ni clears control state and restores height 512, width 512, limit 256.
module mandelbrot_escape_pixel (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mep_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mep_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_row [11:0], pixel_column [23:12]
  input  logic [mep_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // iteration_count [15:0]
  output logic [mep_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // in_set [0]
  output logic                                m_axis_tuser
);
  import mep_pkg::*;

  state_e state_q, state_d;

  logic [DIM_BITS-1:0]   height_q, width_q;
  logic [COUNT_BITS-1:0] limit_q;

  logic [PIX_BITS-1:0]   row_q;
  logic                  sel_im_q;
  logic [DVD_BITS-1:0]   dvd_q;
  logic [DIM_BITS-1:0]   rem_q;
  logic [COORD_BITS-1:0] quo_q;
  logic                  ovf_q;
  logic [DCNT_BITS-1:0]  dcnt_q;

  logic signed [COORD_BITS-1:0] cre_q, cim_q, zr_q, zi_q;
  logic [PROD_BITS-1:0]         sr_q, si_q, pr_q;
  logic signed [COORD_BITS-2:0] x_q;
  logic                         neg_q;
  logic [COUNT_BITS-1:0]        n_q;

  logic                  m_valid_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  out_set_q;

  logic                  in_acc, out_free;
  logic [DIM_BITS-1:0]   height_eff, width_eff, div_d;
  logic [DIM_BITS:0]     trial;
  logic                  q_bit;
  logic [DIM_BITS-1:0]   rem_next;
  logic [COORD_BITS:0]   map_diff;
  logic [COORD_BITS-1:0] map_val;
  logic [COORD_BITS-1:0] ar, ai;
  logic                  too_big;
  logic [MAG_BITS-1:0]   mul_a, mul_b;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS:0]    sq_sum;
  logic                  escaped;
  logic [COUNT_BITS-1:0] n_inc;
  logic                  at_limit;
  logic signed [PROD_BITS:0]    sq_diff, pr_signed;
  logic signed [COORD_BITS-1:0] y_val;
  logic signed [COORD_BITS:0]   re_sum, im_sum;
  logic [COORD_BITS-1:0]        re_sat, im_sat;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS:0] s);
    logic [COORD_BITS-1:0] r;
    if (s[COORD_BITS] != s[COORD_BITS-1]) begin
      r = s[COORD_BITS] ? Q_MIN : Q_MAX;
    end else begin
      r = s[COORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_ONE;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_set_q;

  // Divider: restoring long division, one quotient bit per cycle.
  assign height_eff = clamp_dim(height_q);
  assign width_eff  = clamp_dim(width_q);
  assign div_d      = sel_im_q ? height_eff : width_eff;
  assign trial      = {rem_q, dvd_q[DVD_BITS-1]};
  assign q_bit      = (trial >= {1'b0, div_d});
  assign rem_next   = q_bit ? DIM_BITS'(trial - {1'b0, div_d}) : DIM_BITS'(trial);

  assign map_diff = {1'b0, quo_q} - {1'b0, (sel_im_q ? IM_OFFSET : RE_OFFSET)};
  assign map_val  = (ovf_q || (!map_diff[COORD_BITS] && map_diff[COORD_BITS-1])) ?
                    Q_MAX : map_diff[COORD_BITS-1:0];

  // Iteration datapath around the shared multiplier.
  assign ar      = zr_q[COORD_BITS-1] ? COORD_BITS'(-zr_q) : COORD_BITS'(zr_q);
  assign ai      = zi_q[COORD_BITS-1] ? COORD_BITS'(-zi_q) : COORD_BITS'(zi_q);
  assign too_big = (ar[COORD_BITS-1:MAG_BITS] != '0) || (ai[COORD_BITS-1:MAG_BITS] != '0);

  always_comb begin
    unique case (state_q)
      ST_SQR:  begin mul_a = ar[MAG_BITS-1:0]; mul_b = ar[MAG_BITS-1:0]; end
      ST_SQI:  begin mul_a = ai[MAG_BITS-1:0]; mul_b = ai[MAG_BITS-1:0]; end
      default: begin mul_a = ar[MAG_BITS-1:0]; mul_b = ai[MAG_BITS-1:0]; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign sq_sum   = {1'b0, sr_q} + {1'b0, si_q};
  assign escaped  = sq_sum[PROD_BITS];
  assign n_inc    = n_q + COUNT_BITS'(1);
  assign at_limit = !(n_inc < limit_q);
  assign sq_diff  = $signed({1'b0, sr_q}) - $signed({1'b0, si_q});

  assign pr_signed = neg_q ? -$signed({1'b0, pr_q}) : $signed({1'b0, pr_q});
  assign y_val     = pr_signed[PROD_BITS:FRACTION_BITS-1];
  assign re_sum    = {{2{x_q[COORD_BITS-2]}}, x_q} + {cre_q[COORD_BITS-1], cre_q};
  assign im_sum    = {y_val[COORD_BITS-1], y_val} + {cim_q[COORD_BITS-1], cim_q};
  assign re_sat    = sat_coord(re_sum);
  assign im_sat    = sat_coord(im_sum);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_DIV;
      ST_DIV:  if (dcnt_q == DIV_LAST) state_d = ST_MAP;
      ST_MAP:  state_d = sel_im_q ? ST_SQR : ST_DIV;
      ST_SQR:  state_d = too_big ? ST_DONE : ST_SQI;
      ST_SQI:  state_d = ST_MXY;
      ST_MXY:  state_d = (escaped || at_limit) ? ST_DONE : ST_UPD;
      ST_UPD:  state_d = ST_SQR;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      height_q  <= HEIGHT_RESET;
      width_q   <= WIDTH_RESET;
      limit_q   <= LIMIT_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HEIGHT:   height_q <= cfg_data_i[DIM_BITS-1:0];
          CFG_WIDTH:    width_q  <= cfg_data_i[DIM_BITS-1:0];
          CFG_MAX_ITER: limit_q  <= cfg_data_i[COUNT_BITS-1:0];
          default:      ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        row_q    <= s_axis_tdata[PIX_BITS-1:0];
        sel_im_q <= 1'b0;
        dvd_q    <= {s_axis_tdata[2*PIX_BITS-1:PIX_BITS], 1'b0, FRACTION_BITS'(0)};
        rem_q    <= '0;
        quo_q    <= '0;
        ovf_q    <= 1'b0;
        dcnt_q   <= '0;
      end
      ST_DIV: begin
        dvd_q  <= {dvd_q[DVD_BITS-2:0], 1'b0};
        rem_q  <= rem_next;
        quo_q  <= {quo_q[COORD_BITS-2:0], q_bit};
        ovf_q  <= ovf_q | quo_q[COORD_BITS-1];
        dcnt_q <= dcnt_q + DCNT_BITS'(1);
      end
      ST_MAP: begin
        if (sel_im_q) begin
          cim_q <= map_val;
        end else begin
          cre_q <= map_val;
        end
        sel_im_q <= 1'b1;
        dvd_q    <= {row_q, 1'b0, FRACTION_BITS'(0)};
        rem_q    <= '0;
        quo_q    <= '0;
        ovf_q    <= 1'b0;
        dcnt_q   <= '0;
        zr_q     <= '0;
        zi_q     <= '0;
        n_q      <= '0;
      end
      ST_SQR: sr_q <= prod;
      ST_SQI: si_q <= prod;
      ST_MXY: begin
        pr_q  <= prod;
        x_q   <= sq_diff[PROD_BITS:FRACTION_BITS];
        neg_q <= zr_q[COORD_BITS-1] ^ zi_q[COORD_BITS-1];
        if (!escaped) n_q <= n_inc;
      end
      ST_UPD: begin
        zr_q <= re_sat;
        zi_q <= im_sat;
      end
      ST_DONE: begin
        if (out_free) begin
          out_count_q <= n_q;
          out_set_q   <= (n_q == limit_q);
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/mep_checker.sv]
// Port-level checks for the Mandelbrot escape-time pixel block.
module mep_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mep_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tuser
);
  import mep_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a pixel is in flight");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != '0)
    else $error("result word carries a zero iteration count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);

[bench/tb_mandelbrot_escape_pixel.sv]
// Self-checking bench for the Mandelbrot escape-time pixel, built on a fixed-point escape model.
module tb_mandelbrot_escape_pixel;
  import mep_pkg::*;

  localparam int     FRAC        = FRACTION_BITS;
  localparam longint COORD_TOP   = (longint'(1) << (FRAC + 3)) - 1;
  localparam longint COORD_FLOOR = -COORD_TOP - 1;
  localparam longint TWO_MAG     = longint'(1) << (FRAC + 1);
  localparam longint RADIUS_SQ   = longint'(1) << (2 * FRAC + 2);
  localparam longint RE_SHIFT    = longint'(3) << (FRAC - 1);
  localparam longint IM_SHIFT    = longint'(1) << FRAC;
  localparam int     PHASES      = 12;
  localparam int     PHASE_ITEMS = 145;
  localparam int     HOLD_AFTER  = 30;
  localparam int     HOLD_CYCLES = 3000;
  localparam int     SETTLE      = 150;
  localparam int     CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic        in_set;
    logic [15:0] count;
  } escape_t;

  typedef enum bit {PROBE_PIXEL, PROBE_WRITE} probe_kind_e;

  typedef struct packed {
    probe_kind_e kind;
    cfg_reg_e    sel;
    logic [15:0] value;
    logic [11:0] row;
    logic [11:0] col;
    logic        known;
    escape_t     want;
  } probe_t;

  localparam probe_t PROBES [30] = '{
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd384,  1'b1, '{1'b1, 16'd256}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd256,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd4095, 12'd4095, 1'b1, '{1'b0, 16'd1}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd0,    12'd4095, 1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd4095, 12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd448,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'hAAA,  12'h555,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'h555,  12'hAAA,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd511,  12'd511,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd128,  12'd256,  1'b0, '{1'b0, 16'd0}},
    '{PROBE_WRITE, CFG_MAX_ITER, 16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd384,  1'b1, '{1'b0, 16'd1}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd4095, 12'd4095, 1'b1, '{1'b0, 16'd1}},
    '{PROBE_WRITE, CFG_MAX_ITER, 16'd1,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd256,  12'd384,  1'b1, '{1'b1, 16'd1}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd1000, 12'd20,   1'b1, '{1'b1, 16'd1}},
    '{PROBE_WRITE, CFG_HEIGHT,   16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_WRITE, CFG_WIDTH,    16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_WRITE, CFG_MAX_ITER, 16'hFFFF,  12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd1,    12'd1,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd4095, 12'd4095, 1'b1, '{1'b0, 16'd1}},
    '{PROBE_WRITE, CFG_MAX_ITER, 16'd3,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_WRITE, CFG_HEIGHT,   16'd8191,  12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_WRITE, CFG_WIDTH,    16'd5000,  12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd2048, 12'd3072, 1'b1, '{1'b1, 16'd3}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd0,    12'd0,    1'b0, '{1'b0, 16'd0}},
    '{PROBE_PIXEL, CFG_HEIGHT,   16'd0,     12'd4095, 12'd2047, 1'b0, '{1'b0, 16'd0}}
  };

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // pixel_row [11:0], pixel_column [23:12]
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // iteration_count [15:0]
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  // in_set [0]
  logic                     m_axis_tuser;

  logic [12:0] height_q = HEIGHT_RESET;
  logic [12:0] width_q  = WIDTH_RESET;
  logic [15:0] limit_q  = LIMIT_RESET;

  escape_t escapes_due [$];
  int      errors       = 0;
  int      results_seen = 0;
  int      cycle_count  = 0;
  bit      quiet        = 1'b0;

  mandelbrot_escape_pixel dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned span_of(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_FLOOR) return COORD_FLOOR;
    return v;
  endfunction

  function automatic longint plane_coord(logic [11:0] p, logic [12:0] d, longint shift);
    longint pos;
    pos = (longint'(p) << (FRAC + 1)) / longint'(span_of(d)) - shift;
    return clamp_coord(pos);
  endfunction

  function automatic escape_t escape_of(logic [11:0] row, logic [11:0] col);
    longint      c_re, c_im, re, im, re_sq, im_sq, im_next;
    int unsigned n;
    escape_t     r;
    c_re = plane_coord(col, width_q, RE_SHIFT);
    c_im = plane_coord(row, height_q, IM_SHIFT);
    re = 0;
    im = 0;
    n = 0;
    while (1) begin
      if (re >= TWO_MAG || re <= -TWO_MAG || im >= TWO_MAG || im <= -TWO_MAG) break;
      re_sq = re * re;
      im_sq = im * im;
      if (re_sq + im_sq >= RADIUS_SQ) break;
      n++;
      if (n >= limit_q) break;
      im_next = clamp_coord(((2 * re * im) >>> FRAC) + c_im);
      re = clamp_coord(((re_sq - im_sq) >>> FRAC) + c_re);
      im = im_next;
    end
    r.in_set = (n == limit_q);
    r.count  = 16'(n);
    return r;
  endfunction

  function automatic logic [15:0] random_span();
    logic [12:0] span;
    span = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                       : 13'($urandom_range(1, 600));
    return {3'($urandom_range(0, 7)), span};
  endfunction

  function automatic logic [11:0] random_index(logic [12:0] d);
    if ($urandom_range(0, 4) == 0) return 12'($urandom);
    return 12'($urandom_range(0, span_of(d) - 1));
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic write_reg(cfg_reg_e sel, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      CFG_HEIGHT:   height_q = value[12:0];
      CFG_WIDTH:    width_q  = value[12:0];
      CFG_MAX_ITER: limit_q  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] row, logic [11:0] col, bit known, escape_t given);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    escapes_due.push_back(known ? given : escape_of(row, col));
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (escapes_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] h, w, lim;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(PROBES); i++) begin
      if (PROBES[i].kind == PROBE_WRITE) begin
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(PROBES[i].sel, PROBES[i].value);
      end else begin
        send_pixel(PROBES[i].row, PROBES[i].col, PROBES[i].known, PROBES[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin h = 16'd512;  w = 16'd512;  lim = 16'd256;  end
        1: begin h = 16'hFFFF; w = 16'd4096; lim = 16'd1;    end
        2: begin h = 16'd0;    w = 16'd0;    lim = 16'hFFFF; end
        3: begin h = 16'd100;  w = 16'd150;  lim = 16'd0;    end
        default: begin
          h   = random_span();
          w   = random_span();
          lim = 16'($urandom_range(1, 40));
        end
      endcase
      s_axis_tvalid <= 1'b0;
      drain();
      quiet = (phase == PHASES - 1);
      write_reg(CFG_HEIGHT, h);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_MAX_ITER, lim);
      repeat (PHASE_ITEMS) send_pixel(random_index(height_q), random_index(width_q), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // A long hold of the result side lets the block fill up and stall its input word.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    escape_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (escapes_due.size() == 0) begin
        report_mismatch($sformatf("word %0d not expected: in_set=%0d count=%0d",
                                  results_seen, m_axis_tuser, m_axis_tdata));
      end else begin
        want = escapes_due.pop_front();
        if (m_axis_tuser !== want.in_set) begin
          report_mismatch($sformatf("word %0d in_set got %0d expected %0d",
                                    results_seen, m_axis_tuser, want.in_set));
        end
        if (m_axis_tdata !== want.count) begin
          report_mismatch($sformatf("word %0d iteration_count got %0d expected %0d",
                                    results_seen, m_axis_tdata, want.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
